[hdl/dbpe_pkg.sv]
// Shared package for the disc brush paint engine.
// Holds frame geometry, field widths, operation and button codes, register indexes,
// the command and status structs between controller and datapath, and a square-step helper.
`timescale 1ns / 1ps

package dbpe_pkg;

   // Frame store geometry. The store is addressed as {row, column}.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int AW         = XW + YW;
   localparam int MEM_DEPTH  = 2 ** AW;

   // Widths of the visible size, able to hold MAX_WIDTH and MAX_HEIGHT themselves.
   localparam int VWW   = $clog2(MAX_WIDTH + 1);
   localparam int VHW   = $clog2(MAX_HEIGHT + 1);
   localparam int FW    = 11;
   localparam int CMPWW = (FW > VWW) ? FW : VWW;
   localparam int CMPHW = (FW > VHW) ? FW : VHW;

   // Field and datapath widths.
   localparam int OPW    = 2;
   localparam int BTNW   = 3;
   localparam int PW     = 12;
   localparam int CW     = 14;
   localparam int COLW   = 24;
   localparam int RW     = 7;
   localparam int DW     = 8;
   localparam int SQW    = 14;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 24;

   localparam logic [RW-1:0] RADIUS_MIN   = 7'd2;
   localparam logic [RW-1:0] RADIUS_MAX   = 7'd80;
   localparam logic [RW-1:0] RADIUS_RESET = 7'd12;
   localparam logic [RW-1:0] RADIUS_STEP  = 7'd2;

   localparam logic [FW-1:0]   WIDTH_RESET      = 11'd900;
   localparam logic [FW-1:0]   HEIGHT_RESET     = 11'd600;
   localparam logic [COLW-1:0] BRUSH_RESET      = 24'hFFC828;
   localparam logic [COLW-1:0] BACKGROUND_RESET = 24'h0C0C10;

   typedef enum logic [OPW-1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MOTION  = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   localparam logic [BTNW-1:0] BTN_LEFT       = 3'd1;
   localparam logic [BTNW-1:0] BTN_RIGHT      = 3'd3;
   localparam logic [BTNW-1:0] BTN_WHEEL_UP   = 3'd4;
   localparam logic [BTNW-1:0] BTN_WHEEL_DOWN = 3'd5;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FRAME_WIDTH      = 2'd0,
      CSR_FRAME_HEIGHT     = 2'd1,
      CSR_BRUSH_COLOR      = 2'd2,
      CSR_BACKGROUND_COLOR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic loop_init;
      logic stamp_step;
      logic fill_step;
      logic clr_step;
      logic rd_issue;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_stamp;
      logic is_fill;
      logic is_read;
      logic stamp_last;
      logic fill_last;
      logic clr_last;
      logic rsp_free;
   } status_type;

   // (d + 1)^2 from d^2: add 2d + 1.
   function automatic logic [SQW-1:0] next_square(input logic [SQW-1:0] sq,
                                                  input logic signed [DW-1:0] d);
      logic signed [SQW:0] t;
      t = $signed({1'b0, sq}) + $signed({{(SQW - DW){d[DW-1]}}, d, 1'b1});
      return t[SQW-1:0];
   endfunction

endpackage

[hdl/dbpe_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth come from its parameters.
`timescale 1ns / 1ps

module dbpe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dbpe_ctrl.sv]
// Controller state machine of the paint engine: clearing pass, item intake,
// stamp and fill sweeps, pixel read and result hand-off. Depends on dbpe_pkg.
`timescale 1ns / 1ps

module dbpe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dbpe_pkg::status_type st,
   output dbpe_pkg::cmd_type  cmd
);
   import dbpe_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_DISPATCH = 7'b0000100,
      ST_STAMP    = 7'b0001000,
      ST_FILL     = 7'b0010000,
      ST_READ     = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.loop_init = 1'b1;
            if (st.is_stamp) begin
               state_in = ST_STAMP;
            end else if (st.is_fill) begin
               state_in = ST_FILL;
            end else if (st.is_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_STAMP: begin
            cmd.stamp_step = 1'b1;
            if (st.stamp_last) begin
               state_in = ST_RESP;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (st.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (st.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/dbpe_dp.sv]
// Datapath of the paint engine: configuration registers, brush state, item capture,
// disc and frame sweep counters, store address generation and the result register.
// Depends on dbpe_pkg; drives the frame store ports of a dbpe_ram instance.
`timescale 1ns / 1ps

module dbpe_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dbpe_pkg::OPW-1:0]    req_operation,
   input  logic [dbpe_pkg::BTNW-1:0]   req_button,
   input  logic signed [dbpe_pkg::PW-1:0] req_pointer_x,
   input  logic signed [dbpe_pkg::PW-1:0] req_pointer_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dbpe_pkg::CSR_IW-1:0] csr_index,
   input  logic [dbpe_pkg::CSR_DW-1:0] csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dbpe_pkg::COLW-1:0]   rsp_pixel_color,
   output logic [dbpe_pkg::RW-1:0]     rsp_brush_radius_now,
   output logic                        rsp_painting_now,
   input  dbpe_pkg::cmd_type           cmd,
   output dbpe_pkg::status_type        st,
   output logic                        mem_wr_en,
   output logic [dbpe_pkg::AW-1:0]     mem_wr_addr,
   output logic [dbpe_pkg::COLW-1:0]   mem_wr_data,
   output logic                        mem_rd_en,
   output logic [dbpe_pkg::AW-1:0]     mem_rd_addr,
   input  logic [dbpe_pkg::COLW-1:0]   mem_rd_data
);
   import dbpe_pkg::*;

   function automatic logic in_frame(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y,
                                     input logic [VWW-1:0] w,
                                     input logic [VHW-1:0] h);
      return !x[CW-1] && !y[CW-1] &&
             (x < $signed(CW'(w))) && (y < $signed(CW'(h)));
   endfunction

   // Configuration registers.
   logic [FW-1:0]   width_ff, width_in;
   logic [FW-1:0]   height_ff, height_in;
   logic [COLW-1:0] brush_ff, brush_in;
   logic [COLW-1:0] background_ff, background_in;

   // Brush state.
   logic [RW-1:0] radius_ff, radius_in;
   logic          flag_ff, flag_in;

   // Captured item.
   logic [OPW-1:0]        op_ff, op_in;
   logic [BTNW-1:0]       btn_ff, btn_in;
   logic signed [PW-1:0]  px_ff, px_in;
   logic signed [PW-1:0]  py_ff, py_in;

   // Sweep counters.
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQW-1:0]       dx2_ff, dx2_in, dy2_ff, dy2_in, r2_ff, r2_in;
   logic [XW-1:0]        fx_ff, fx_in;
   logic [YW-1:0]        fy_ff, fy_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic [COLW-1:0] pixel_ff, pixel_in;
   logic [RW-1:0]   rad_out_ff, rad_out_in;
   logic            paint_out_ff, paint_out_in;

   logic [VWW-1:0]       vis_w;
   logic [VHW-1:0]       vis_h;
   logic signed [DW-1:0] rad_s;
   logic [SQW-1:0]       rsq;
   logic signed [CW-1:0] cur_x, cur_y, rd_x, rd_y;
   logic                 in_disc, fx_wrap;

   assign vis_w = (CMPWW'(width_ff) > CMPWW'(MAX_WIDTH)) ? VWW'(MAX_WIDTH) : VWW'(width_ff);
   assign vis_h = (CMPHW'(height_ff) > CMPHW'(MAX_HEIGHT)) ? VHW'(MAX_HEIGHT)
                                                            : VHW'(height_ff);

   assign rad_s = $signed({1'b0, radius_ff});
   assign rsq   = SQW'(radius_ff) * SQW'(radius_ff);
   assign cur_x = CW'(px_ff) + CW'(dx_ff);
   assign cur_y = CW'(py_ff) + CW'(dy_ff);
   assign rd_x  = CW'(px_ff);
   assign rd_y  = CW'(py_ff);
   assign in_disc = ({1'b0, dx2_ff} + {1'b0, dy2_ff}) <= {1'b0, r2_ff};
   assign fx_wrap = (VWW'(fx_ff) + VWW'(1)) == vis_w;

   assign csr_ready = 1'b1;

   always_comb begin
      st.is_stamp   = ((op_ff == OP_PRESS) && (btn_ff == BTN_LEFT)) ||
                      ((op_ff == OP_MOTION) && flag_ff);
      st.is_fill    = (op_ff == OP_PRESS) && (btn_ff == BTN_RIGHT) &&
                      (vis_w != '0) && (vis_h != '0);
      st.is_read    = (op_ff == OP_READ) && in_frame(rd_x, rd_y, vis_w, vis_h);
      st.stamp_last = (dx_ff == rad_s) && (dy_ff == rad_s);
      st.fill_last  = fx_wrap && ((VHW'(fy_ff) + VHW'(1)) == vis_h);
      st.clr_last   = &clr_addr_ff;
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Configuration writes.
   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      brush_in      = brush_ff;
      background_in = background_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:      width_in      = csr_wdata[FW-1:0];
            CSR_FRAME_HEIGHT:     height_in     = csr_wdata[FW-1:0];
            CSR_BRUSH_COLOR:      brush_in      = csr_wdata[COLW-1:0];
            CSR_BACKGROUND_COLOR: background_in = csr_wdata[COLW-1:0];
            default:              width_in      = width_ff;
         endcase
      end
   end

   // Brush state and item capture. The radius and flag move when the beat is taken,
   // which never affects the disc of the same item.
   always_comb begin
      radius_in = radius_ff;
      flag_in   = flag_ff;
      op_in     = op_ff;
      btn_in    = btn_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      if (cmd.accept) begin
         op_in = req_operation;
         btn_in = req_button;
         px_in = req_pointer_x;
         py_in = req_pointer_y;
         if (req_operation == OP_PRESS) begin
            if (req_button == BTN_LEFT) begin
               flag_in = 1'b1;
            end else if (req_button == BTN_WHEEL_UP) begin
               radius_in = (radius_ff >= RADIUS_MAX - RADIUS_STEP) ? RADIUS_MAX
                                                                  : radius_ff + RADIUS_STEP;
            end else if (req_button == BTN_WHEEL_DOWN) begin
               radius_in = (radius_ff <= RADIUS_MIN + RADIUS_STEP) ? RADIUS_MIN
                                                                  : radius_ff - RADIUS_STEP;
            end
         end else if ((req_operation == OP_RELEASE) && (req_button == BTN_LEFT)) begin
            flag_in = 1'b0;
         end
      end
   end

   // Disc sweep runs row by row over the bounding square; squares are kept by increments.
   always_comb begin
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dx2_in      = dx2_ff;
      dy2_in      = dy2_ff;
      r2_in       = r2_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      clr_addr_in = clr_addr_ff;
      if (cmd.loop_init) begin
         dx_in  = -rad_s;
         dy_in  = -rad_s;
         dx2_in = rsq;
         dy2_in = rsq;
         r2_in  = rsq;
         fx_in  = '0;
         fy_in  = '0;
      end
      if (cmd.stamp_step) begin
         if (dx_ff == rad_s) begin
            dx_in  = -rad_s;
            dx2_in = r2_ff;
            dy_in  = dy_ff + DW'(1);
            dy2_in = next_square(dy2_ff, dy_ff);
         end else begin
            dx_in  = dx_ff + DW'(1);
            dx2_in = next_square(dx2_ff, dx_ff);
         end
      end
      if (cmd.fill_step) begin
         if (fx_wrap) begin
            fx_in = '0;
            fy_in = fy_ff + YW'(1);
         end else begin
            fx_in = fx_ff + XW'(1);
         end
      end
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
   end

   // Store write port.
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      if (cmd.clr_step) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = BACKGROUND_RESET;
      end else if (cmd.fill_step) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = {fy_ff, fx_ff};
         mem_wr_data = background_ff;
      end else if (cmd.stamp_step) begin
         mem_wr_en   = in_disc && in_frame(cur_x, cur_y, vis_w, vis_h);
         mem_wr_addr = {cur_y[YW-1:0], cur_x[XW-1:0]};
         mem_wr_data = brush_ff;
      end
   end

   assign mem_rd_en   = cmd.rd_issue;
   assign mem_rd_addr = {rd_y[YW-1:0], rd_x[XW-1:0]};

   // Result register: a new beat may load in the cycle the old one is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      rad_out_in   = rad_out_ff;
      paint_out_in = paint_out_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         pixel_in     = st.is_read ? mem_rd_data : '0;
         rad_out_in   = radius_ff;
         paint_out_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         brush_ff      <= BRUSH_RESET;
         background_ff <= BACKGROUND_RESET;
         radius_ff     <= RADIUS_RESET;
         flag_ff       <= 1'b0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         brush_ff      <= brush_in;
         background_ff <= background_in;
         radius_ff     <= radius_in;
         flag_ff       <= flag_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      btn_ff       <= btn_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dx2_ff       <= dx2_in;
      dy2_ff       <= dy2_in;
      r2_ff        <= r2_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      pixel_ff     <= pixel_in;
      rad_out_ff   <= rad_out_in;
      paint_out_ff <= paint_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_color      = pixel_ff;
   assign rsp_brush_radius_now = rad_out_ff;
   assign rsp_painting_now     = paint_out_ff;

endmodule

[hdl/disc_brush_paint_engine_top.sv]
// Disc brush paint engine: one beat in, one beat out, one item in progress at a time.
// A disc stamp sweeps the bounding square of the disc and a frame fill every visible pixel;
// the store takes one write per cycle.
// After a synchronous reset a clearing pass writes the background reset colour into all
// 1048576 store entries, one per cycle; no beat is taken until it ends, csr writes are.
// Depends on dbpe_pkg, dbpe_ctrl, dbpe_dp and dbpe_ram.
`timescale 1ns / 1ps

module disc_brush_paint_engine_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dbpe_pkg::OPW-1:0]    req_operation,
   input  logic [dbpe_pkg::BTNW-1:0]   req_button,
   input  logic signed [dbpe_pkg::PW-1:0] req_pointer_x,
   input  logic signed [dbpe_pkg::PW-1:0] req_pointer_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dbpe_pkg::COLW-1:0]   rsp_pixel_color,
   output logic [dbpe_pkg::RW-1:0]     rsp_brush_radius_now,
   output logic                        rsp_painting_now,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dbpe_pkg::CSR_IW-1:0] csr_index,
   input  logic [dbpe_pkg::CSR_DW-1:0] csr_wdata
);
   import dbpe_pkg::*;

   cmd_type         cmd;
   status_type      st;
   logic            mem_wr_en, mem_rd_en;
   logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
   logic [COLW-1:0] mem_wr_data, mem_rd_data;

   dbpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   dbpe_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_operation        (req_operation),
      .req_button           (req_button),
      .req_pointer_x        (req_pointer_x),
      .req_pointer_y        (req_pointer_y),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pixel_color      (rsp_pixel_color),
      .rsp_brush_radius_now (rsp_brush_radius_now),
      .rsp_painting_now     (rsp_painting_now),
      .cmd                  (cmd),
      .st                   (st),
      .mem_wr_en            (mem_wr_en),
      .mem_wr_addr          (mem_wr_addr),
      .mem_wr_data          (mem_wr_data),
      .mem_rd_en            (mem_rd_en),
      .mem_rd_addr          (mem_rd_addr),
      .mem_rd_data          (mem_rd_data)
   );

   dbpe_ram #(
      .WIDTH (COLW),
      .DEPTH (MEM_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // No beat is taken while the clearing pass is still writing the store.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_ready)
      else $error("input beat offered ready during the clearing pass");

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before it was taken");

   // Only one source drives the store at a time.
   a_single_store_user: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.stamp_step, cmd.fill_step, cmd.clr_step, cmd.rd_issue}))
      else $error("more than one store command in a cycle");

   // The reported radius always lies within the wheel limits.
   a_radius_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_brush_radius_now >= RADIUS_MIN) &&
                     (rsp_brush_radius_now <= RADIUS_MAX)))
      else $error("reported brush radius out of range");

endmodule
